### hdl/integer_set_store_assert.svh
// Assertion macros for the integer set store checker.
// Needs signals named clock and reset in the scope of use.
`ifndef INTEGER_SET_STORE_ASSERT_SVH
`define INTEGER_SET_STORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define IGS_ASSERT_SAME(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("integer_set_store check failed");

// condition holds in the cycle after the trigger
`define IGS_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("integer_set_store check failed");

`endif

### hdl/igs_pkg.sv
// Shared constants and types for the integer set store.
// No dependencies.
package igs_pkg;

   localparam int CAPACITY  = 128;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int DATA_W    = 32;
   localparam int OP_W      = 2;
   localparam int OUT_CNT_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_MEMBER = 2'd2
   } op_type;

   // one-hot controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   // control broadcast to every cell
   typedef struct packed {
      logic capture;   // take a fresh match flag
      logic insert;    // cell at the fill position loads the key
      logic remove;    // cells at or past the hole take their neighbour's entry
   } cell_ctl_type;

endpackage

### hdl/igs_cell.sv
// One storage cell of the set chain: an entry, its match flag and the
// shift-down path from its upper neighbour. Depends on igs_pkg.
module igs_cell (
   input  logic                        clock,
   input  igs_pkg::cell_ctl_type       ctl,
   input  logic [igs_pkg::IDX_W-1:0]   index,
   input  logic [igs_pkg::CNT_W-1:0]   count,
   input  logic [igs_pkg::DATA_W-1:0]  key,
   input  logic                        prefix,
   input  logic [igs_pkg::DATA_W-1:0]  next_entry,
   output logic [igs_pkg::DATA_W-1:0]  entry,
   output logic                        hit
);
   import igs_pkg::*;

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              hit_ff, hit_in;
   logic              occupied;

   assign occupied = CNT_W'(index) < count;

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      if (ctl.capture) begin
         hit_in = occupied && (entry_ff == key);
      end
      priority if (ctl.insert && (CNT_W'(index) == count)) begin
         entry_in = key;
      end else if (ctl.remove && prefix) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

### hdl/igs_prefix.sv
// Prefix OR over the cell match flags: bit i is set when some cell at or
// below i matched. Log-depth form. Depends on igs_pkg.
module igs_prefix (
   input  logic [igs_pkg::CAPACITY-1:0] hit,
   output logic [igs_pkg::CAPACITY-1:0] prefix
);
   import igs_pkg::*;

   always_comb begin
      prefix = hit;
      for (int k = 0; k < IDX_W; k++) begin
         prefix = prefix | (prefix << (1 << k));
      end
   end

endmodule

### hdl/integer_set_store.sv
// Integer set store: a chain of cells, one per entry, with a count.
// Each word is compared on acceptance while idle, then applied in the update state;
// the update waits while an earlier result still sits unread in the output register,
// and the result word is registered as it commits. No new word is taken until then.
// Reset: count and handshake state clear; cell contents are left as they are.
module integer_set_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [igs_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [igs_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_was_present,
   output logic [igs_pkg::OUT_CNT_W-1:0]     rsp_count_after,
   output logic                              rsp_rejected
);
   import igs_pkg::*;

   state_type              state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [DATA_W-1:0]      value_ff, value_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   present_ff, present_in;
   logic                   rejected_ff, rejected_in;
   logic [OUT_CNT_W-1:0]   cnt_out_ff, cnt_out_in;

   cell_ctl_type           ctl;
   logic [CAPACITY-1:0]    hit;
   logic [CAPACITY-1:0]    prefix;
   logic [DATA_W-1:0]      entry [CAPACITY];
   logic [DATA_W-1:0]      key;
   logic                   accept;
   logic                   commit;
   logic                   present;
   logic                   full;
   logic                   do_insert;
   logic                   do_reject;
   logic                   do_delete;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign present   = prefix[CAPACITY-1];
   assign full      = (count_ff == CNT_W'(CAPACITY));
   // compare against the port while idle, insert the held copy during update
   assign key       = (state_ff == ST_IDLE) ? req_value : value_ff;

   always_comb begin
      do_insert = 1'b0;
      do_reject = 1'b0;
      do_delete = 1'b0;
      unique case (op_ff)
         OP_INSERT: begin
            do_insert = !present && !full;
            do_reject = !present && full;
         end
         OP_DELETE: begin
            do_delete = present;
         end
         default: begin
            // membership test and the unused code change nothing
         end
      endcase
   end

   assign ctl.capture = accept;
   assign ctl.insert  = commit && do_insert;
   assign ctl.remove  = commit && do_delete;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] upper;
      if (i == CAPACITY - 1) begin : g_top
         assign upper = entry[i];
      end else begin : g_mid
         assign upper = entry[i+1];
      end
      igs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .index      (IDX_W'(i)),
         .count      (count_ff),
         .key        (key),
         .prefix     (prefix[i]),
         .next_entry (upper),
         .entry      (entry[i]),
         .hit        (hit[i])
      );
   end

   igs_prefix u_prefix (
      .hit    (hit),
      .prefix (prefix)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      present_in   = present_ff;
      rejected_in  = rejected_ff;
      cnt_out_in   = cnt_out_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               value_in = req_value;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               if (do_insert) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (do_delete) begin
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_valid_in = 1'b1;
               present_in   = present;
               rejected_in  = do_reject;
               cnt_out_in   = OUT_CNT_W'(count_in);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      present_ff  <= present_in;
      rejected_ff <= rejected_in;
      cnt_out_ff  <= cnt_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_was_present = present_ff;
   assign rsp_rejected    = rejected_ff;
   assign rsp_count_after = cnt_out_ff;

endmodule

### hdl/igs_check.sv
// Port-level checker for the integer set store, bound to the top level.
// Depends on igs_pkg and integer_set_store_assert.svh.
`include "integer_set_store_assert.svh"

module igs_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_was_present,
   input logic [igs_pkg::OUT_CNT_W-1:0]     rsp_count_after,
   input logic                              rsp_rejected
);
   import igs_pkg::*;

   logic [OUT_CNT_W-1:0] full_count;
   logic                 req_word;
   logic                 rsp_stall;

   assign full_count = OUT_CNT_W'(CAPACITY);
   assign req_word   = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;

   // one word in flight: the input is closed after a word is taken
   `IGS_ASSERT_NEXT(a_one_in_flight, req_word, !req_ready)
   // a rejected insert leaves the store full
   `IGS_ASSERT_SAME(a_reject_full, rsp_valid && rsp_rejected, rsp_count_after == full_count)
   // a rejected insert only ever concerns an absent value
   `IGS_ASSERT_SAME(a_reject_absent, rsp_valid && rsp_rejected, !rsp_was_present)
   // stalled result stays valid with its count and presence flag unchanged
   `IGS_ASSERT_NEXT(a_rsp_hold, rsp_stall,
      rsp_valid && $stable(rsp_count_after) && $stable(rsp_was_present))

endmodule

bind integer_set_store igs_check u_igs_check (.*);
